### rtl/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, constants and round functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam word_t IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    // Byte operations of the buffer, chosen by the controller.
    typedef enum logic [1:0] {
        BOP_NONE = 2'd0,
        BOP_DATA = 2'd1,
        BOP_PAD  = 2'd2,
        BOP_ZERO = 2'd3
    } byte_op_t;

    typedef struct packed {
        byte_op_t   byte_op;     // write into buffer at fill index
        logic       count_bits;  // add 8 to bit length
        logic       len_write;   // write length byte at fill index
        logic       start_comp;  // begin 64-round compression
        logic       reset_msg;   // restore IV, clear counters
        logic       out_load;    // load digest word at out index
        logic [2:0] out_index;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill_index;
        logic       comp_busy;
    } dp_status_t;

    function automatic word_t rotr(input word_t v, input int unsigned r);
        rotr = (v >> r) | (v << (32 - r));
    endfunction

    function automatic word_t ssig0(input word_t x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

### rtl/sha256_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one message byte beat.
// ----------------------------------------------------------------------------
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_last;

    modport source (output valid, data_byte, byte_present, is_last, input ready);
    modport sink   (input valid, data_byte, byte_present, is_last, output ready);
endinterface

### rtl/sha256_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying one digest word beat.
// ----------------------------------------------------------------------------
interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha256_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, one round per cycle, chaining words.
// ----------------------------------------------------------------------------
module sha256_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::dp_cmd_t    cmd,
    input  logic [7:0]             data_byte,
    output sha256_pkg::dp_status_t status,
    output logic [31:0]            out_word
);
    import sha256_pkg::*;

    logic [7:0]  buf_mem [64];
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    word_t       chain_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];       // sliding schedule window
    logic [6:0]  round_reg, round_next; // 0..64; 64 = finalize
    logic        busy_reg, busy_next;
    logic        load_reg;          // one cycle: load window and working vars
    word_t       out_reg;

    word_t w_cur, w_new, t1, t2, maj, ch;
    logic [7:0] len_byte;

    // Length byte for positions 56..63, big-endian.
    always_comb
    begin
        unique case (fill_reg[2:0])
            3'd0: len_byte = bits_reg[63:56];
            3'd1: len_byte = bits_reg[55:48];
            3'd2: len_byte = bits_reg[47:40];
            3'd3: len_byte = bits_reg[39:32];
            3'd4: len_byte = bits_reg[31:24];
            3'd5: len_byte = bits_reg[23:16];
            3'd6: len_byte = bits_reg[15:8];
            default: len_byte = bits_reg[7:0];
        endcase
    end

    // Buffer writes: 64 byte registers read at fixed places for the window load.
    always_ff @(posedge clk)
    begin
        if (cmd.len_write)
        begin
            buf_mem[fill_reg] <= len_byte;
        end
        else
        begin
            unique case (cmd.byte_op)
                BOP_DATA: buf_mem[fill_reg] <= data_byte;
                BOP_PAD:  buf_mem[fill_reg] <= PAD_BYTE;
                BOP_ZERO: buf_mem[fill_reg] <= 8'h00;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        bits_next = bits_reg;
        if (cmd.byte_op != BOP_NONE || cmd.len_write)
        begin
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count_bits)
        begin
            bits_next = bits_reg + 64'd8;
        end
        if (cmd.reset_msg)
        begin
            fill_next = '0;
            bits_next = '0;
        end
    end

    // Round logic.
    assign w_cur = w_reg[0];
    assign w_new = w_reg[0] + ssig0(w_reg[1]) + w_reg[9] + ssig1(w_reg[14]);
    assign ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1    = v_reg[7] + bsig1(v_reg[4]) + ch + ROUND_K[round_reg[5:0]] + w_cur;
    assign t2    = bsig0(v_reg[0]) + maj;

    always_comb
    begin
        busy_next  = busy_reg;
        round_next = round_reg;
        if (cmd.start_comp)
        begin
            busy_next  = 1'b1;
            round_next = '0;
        end
        else if (busy_reg && !load_reg)
        begin
            if (round_reg == 7'd64)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                round_next = round_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            bits_reg  <= '0;
            busy_reg  <= 1'b0;
            load_reg  <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV_WORDS[i];
            end
        end
        else
        begin
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            busy_reg  <= busy_next;
            load_reg  <= cmd.start_comp;
            round_reg <= round_next;
            if (cmd.reset_msg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= IV_WORDS[i];
                end
            end
            else if (busy_reg && !load_reg && round_reg == 7'd64)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + v_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= {buf_mem[4*i], buf_mem[4*i+1], buf_mem[4*i+2], buf_mem[4*i+3]};
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
        end
        else if (busy_reg && round_reg != 7'd64)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.out_load)
        begin
            out_reg <= chain_reg[cmd.out_index];
        end
    end

    assign status.fill_index = fill_reg;
    assign status.comp_busy  = busy_reg;
    assign out_word          = out_reg;

endmodule

### rtl/sha256_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_present,
    input  logic                   in_last,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_index,
    output logic                   out_last,
    input  sha256_pkg::dp_status_t status,
    output sha256_pkg::dp_cmd_t    cmd
);
    import sha256_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WAIT  = 7'b0000010, // compression of a full data block
        S_PAD   = 7'b0000100, // write pad, zero and length bytes
        S_CPAD  = 7'b0001000, // compression of a padding block
        S_LOAD  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_SETUP = 7'b1000000  // compression start cycle
    } state_t;

    state_t     state_reg, state_next;
    logic       padded_reg, padded_next;   // 0x80 already written
    logic       final_reg, final_next;     // padding block carries length
    logic       tofinal_reg, tofinal_next; // after SETUP go to CPAD
    logic [2:0] idx_reg, idx_next;
    logic       acc;

    assign acc       = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;
    assign out_last  = (idx_reg == 3'd7);

    always_comb
    begin
        state_next   = state_reg;
        padded_next  = padded_reg;
        final_next   = final_reg;
        tofinal_next = tofinal_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.byte_op  = BOP_NONE;
        cmd.out_index = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (in_present)
                    begin
                        cmd.byte_op    = BOP_DATA;
                        cmd.count_bits = 1'b1;
                        if (status.fill_index == 6'd63)
                        begin
                            cmd.start_comp = 1'b1;
                            tofinal_next   = 1'b0;
                            state_next     = S_SETUP;
                        end
                    end
                    padded_next = 1'b0;
                    if (in_last)
                    begin
                        final_next = 1'b1; // message must be closed
                        if (!(in_present && status.fill_index == 6'd63))
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else
                    begin
                        final_next = 1'b0;
                    end
                end
            end
            S_SETUP:
            begin
                state_next = tofinal_reg ? S_CPAD : S_WAIT;
            end
            S_WAIT:
            begin
                if (!status.comp_busy)
                begin
                    state_next = final_reg ? S_PAD : S_IDLE;
                end
            end
            S_PAD:
            begin
                if (!padded_reg)
                begin
                    cmd.byte_op = BOP_PAD;
                    padded_next = 1'b1;
                end
                else if (status.fill_index >= LEN_OFFSET && !final_reg)
                begin
                    cmd.byte_op = BOP_ZERO;
                end
                else if (status.fill_index >= LEN_OFFSET)
                begin
                    cmd.len_write = 1'b1;
                end
                else
                begin
                    cmd.byte_op = BOP_ZERO;
                end
                // final_reg here means "this block may carry the length";
                // once 0x80 lands past byte 55 the length goes in a next block.
                if (!padded_reg && status.fill_index >= 6'd56)
                begin
                    final_next = 1'b0;
                end
                if (status.fill_index == 6'd63)
                begin
                    cmd.start_comp = 1'b1;
                    tofinal_next   = 1'b1;
                    state_next     = S_SETUP;
                end
            end
            S_CPAD:
            begin
                if (!status.comp_busy)
                begin
                    if (final_reg)
                    begin
                        state_next = S_LOAD;
                        idx_next   = '0;
                    end
                    else
                    begin
                        final_next = 1'b1;
                        state_next = S_PAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == 3'd7)
                    begin
                        cmd.reset_msg = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            padded_reg  <= 1'b0;
            final_reg   <= 1'b0;
            tofinal_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            padded_reg  <= padded_next;
            final_reg   <= final_next;
            tofinal_reg <= tofinal_next;
            idx_reg     <= idx_next;
        end
    end

endmodule

### rtl/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher top
// Byte-serial SHA-256: absorbs message bytes, pads, emits eight digest words.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle while the block buffer fills; each full
//   64-byte block then holds input during load, 64 rounds, add and return.
// After a last beat: padding bytes go in at one per cycle, then one or two
//   compressions run; each digest word is loaded, then shown until taken.
// Reset: rst_n asynchronous active low; chaining words return to the IV,
//   byte and bit counters clear. The buffer needs no clearing.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
    input  logic         clk,
    input  logic         rst_n,
    sha256_in_if.sink    in_ch,
    sha256_out_if.source out_ch
);
    import sha256_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [31:0] word;

    // Controller: only command/status reach the datapath.
    sha256_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_present (in_ch.byte_present),
        .in_last    (in_ch.is_last),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_index  (out_ch.word_index),
        .out_last   (out_ch.last_word),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: buffer, schedule window, round unit, chaining words.
    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_ch.data_byte),
        .status    (status),
        .out_word  (word)
    );

    assign out_ch.digest_word = word;

endmodule
